// ===== design/ecbu_pkg.sv =====
// shared types, constants and tables for the euler camera basis update block
package ecbu_pkg;

  localparam int VecFracBits   = 14;
  localparam int AngleFracBits = 6;
  localparam int CordicSteps   = 16;

  localparam int DegFrac  = 20;
  localparam int TableLen = 24;
  localparam int CordW    = 34;
  localparam int AngW     = 32;

  localparam logic [2:0] FuncRotate  = 3'd0;
  localparam logic [2:0] FuncForward = 3'd1;
  localparam logic [2:0] FuncBack    = 3'd2;
  localparam logic [2:0] FuncLeft    = 3'd3;
  localparam logic [2:0] FuncRight   = 3'd4;

  localparam logic signed [CordW-1:0] CordicX0 = 34'sd652032874;

  // datapath commands from the controller
  typedef struct packed {
    logic       load_item;
    logic       do_move;
    logic       cordic_start_yaw;
    logic       cordic_start_pitch;
    logic       cordic_step;
    logic       cordic_finish;
    logic [2:0] mul_sel;
  } cmd_t;

  typedef struct packed {
    logic       cordic_last;
  } sts_t;

  function automatic logic signed [AngW-1:0] atan_deg(input logic [4:0] idx);
    logic signed [AngW-1:0] r;
    begin
      case (idx)
        5'd0:  r = 32'sd47185920;
        5'd1:  r = 32'sd27855475;
        5'd2:  r = 32'sd14718068;
        5'd3:  r = 32'sd7471121;
        5'd4:  r = 32'sd3750058;
        5'd5:  r = 32'sd1876857;
        5'd6:  r = 32'sd938658;
        5'd7:  r = 32'sd469357;
        5'd8:  r = 32'sd234682;
        5'd9:  r = 32'sd117342;
        5'd10: r = 32'sd58671;
        5'd11: r = 32'sd29335;
        5'd12: r = 32'sd14668;
        5'd13: r = 32'sd7334;
        5'd14: r = 32'sd3667;
        5'd15: r = 32'sd1833;
        5'd16: r = 32'sd917;
        5'd17: r = 32'sd458;
        5'd18: r = 32'sd229;
        5'd19: r = 32'sd115;
        5'd20: r = 32'sd57;
        5'd21: r = 32'sd29;
        5'd22: r = 32'sd14;
        5'd23: r = 32'sd7;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== design/ecbu_ctrl.sv =====
// controller state machine sequencing moves, two cordic runs and basis products
module ecbu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        func_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ecbu_pkg::sts_t    sts_i,
  output ecbu_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StYaw   = 3'd1;
  localparam logic [2:0] StPitch = 3'd2;
  localparam logic [2:0] StMul   = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;

  logic [2:0] state_q, state_d;
  logic [2:0] msel_q, msel_d;
  logic       acc;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign acc         = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    msel_d  = msel_q;
    cmd_o   = '0;
    cmd_o.mul_sel = msel_q;
    case (state_q)
      StIdle: begin
        if (acc) begin
          cmd_o.load_item = 1'b1;
          if (func_i == ecbu_pkg::FuncRotate) begin
            state_d = StYaw;
          end else begin
            cmd_o.do_move = 1'b1;
            state_d = StOut;
          end
        end
      end
      StYaw: begin
        cmd_o.cordic_start_yaw = 1'b1;
        state_d = StPitch;
        msel_d  = 3'd0;
      end
      StPitch: begin
        if (msel_q == 3'd0) begin
          cmd_o.cordic_step = 1'b1;
          if (sts_i.cordic_last) begin
            msel_d = 3'd1;
          end
        end else if (msel_q == 3'd1) begin
          cmd_o.cordic_finish = 1'b1;
          msel_d = 3'd2;
        end else if (msel_q == 3'd2) begin
          cmd_o.cordic_start_pitch = 1'b1;
          msel_d = 3'd3;
        end else if (msel_q == 3'd3) begin
          cmd_o.cordic_step = 1'b1;
          if (sts_i.cordic_last) begin
            msel_d = 3'd4;
          end
        end else begin
          cmd_o.cordic_finish = 1'b1;
          msel_d  = 3'd0;
          state_d = StMul;
        end
      end
      StMul: begin
        if (msel_q == 3'd3) begin
          msel_d  = 3'd0;
          state_d = StOut;
        end else begin
          msel_d = msel_q + 3'd1;
        end
      end
      StOut: begin
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      msel_q  <= 3'd0;
    end else begin
      state_q <= state_d;
      msel_q  <= msel_d;
    end
  end

endmodule

// ===== design/ecbu_datapath.sv =====
// datapath: angle state, shared cordic unit, product unit and position adders
module ecbu_datapath #(
  parameter int VEC_FRAC_BITS   = ecbu_pkg::VecFracBits,
  parameter int ANGLE_FRAC_BITS = ecbu_pkg::AngleFracBits,
  parameter int CORDIC_STEPS    = ecbu_pkg::CordicSteps
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ecbu_pkg::cmd_t      cmd_i,
  output ecbu_pkg::sts_t      sts_o,
  input  logic [2:0]          func_i,
  input  logic signed [15:0]  yaw_delta_i,
  input  logic signed [15:0]  pitch_delta_i,
  output logic signed [31:0]  pos_x_o,
  output logic signed [31:0]  pos_y_o,
  output logic signed [31:0]  pos_z_o,
  output logic signed [15:0]  fwd_x_o,
  output logic signed [15:0]  fwd_y_o,
  output logic signed [15:0]  fwd_z_o,
  output logic signed [15:0]  right_x_o,
  output logic signed [15:0]  right_z_o,
  output logic signed [15:0]  up_x_o,
  output logic signed [15:0]  up_y_o,
  output logic signed [15:0]  up_z_o,
  output logic signed [15:0]  heading_o
);

  localparam int CW = ecbu_pkg::CordW;
  localparam int AW = ecbu_pkg::AngW;
  localparam int VW = VEC_FRAC_BITS + 2;
  localparam int Steps = (CORDIC_STEPS < ecbu_pkg::TableLen) ? CORDIC_STEPS
                                                             : ecbu_pkg::TableLen;
  localparam int RShift = 30 - VEC_FRAC_BITS;
  localparam logic signed [AW-1:0] DegUnit = AW'(64'sd1 <<< ecbu_pkg::DegFrac);
  localparam logic signed [17:0] YLim = 18'(360 * (1 << ANGLE_FRAC_BITS));
  localparam logic signed [17:0] PLim = 18'(60 * (1 << ANGLE_FRAC_BITS));
  localparam logic signed [VW-1:0] OneV = VW'(1 << VEC_FRAC_BITS);
  localparam logic signed [CW-1:0] RHalf = CW'(64'sd1 <<< (RShift - 1));

  logic signed [17:0] yaw_q, pitch_q;
  logic signed [17:0] ysum, psum;
  logic signed [31:0] pos_q [3];
  logic signed [VW-1:0] fwd_q [3];
  logic signed [VW-1:0] rgt_q [2];
  logic signed [VW-1:0] up_q [3];
  logic signed [VW-1:0] cy_q, sy_q, cp_q, sp_q;

  logic signed [CW-1:0] cx_q, cyv_q;
  logic signed [AW-1:0] ca_q;
  logic                 cneg_q;
  logic [4:0]           cstep_q;

  assign ysum = yaw_q + 18'(yaw_delta_i);
  assign psum = pitch_q + 18'(pitch_delta_i);
  assign sts_o.cordic_last = (cstep_q == 5'(Steps - 1));

  // angle reduction into [-90,90] degrees
  function automatic logic [AW:0] reduce(input logic signed [17:0] ang);
    logic signed [AW-1:0] a;
    logic n;
    begin
      a = AW'(ang) <<< (ecbu_pkg::DegFrac - ANGLE_FRAC_BITS);
      n = 1'b0;
      if (a > 180 * DegUnit) a = a - 360 * DegUnit;
      if (a < -180 * DegUnit) a = a + 360 * DegUnit;
      if (a > 90 * DegUnit) begin
        a = a - 180 * DegUnit;
        n = 1'b1;
      end else if (a < -90 * DegUnit) begin
        a = a + 180 * DegUnit;
        n = 1'b1;
      end
      return {n, a};
    end
  endfunction

  function automatic logic signed [VW-1:0] fin(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    begin
      r = (v + RHalf) >>> RShift;
      if (r > CW'(OneV)) r = CW'(OneV);
      if (r < -CW'(OneV)) r = -CW'(OneV);
      return VW'(r);
    end
  endfunction

  logic [AW:0] red_y, red_p;
  assign red_y = reduce(yaw_q);
  assign red_p = reduce(pitch_q);

  logic signed [CW-1:0] fx, fy;
  assign fx = cneg_q ? -cx_q : cx_q;
  assign fy = cneg_q ? -cyv_q : cyv_q;

  // product unit, one product per cycle
  logic signed [VW-1:0] ma, mb;
  logic signed [2*VW-1:0] prod;
  logic signed [VW-1:0] prod_r;
  always_comb begin
    case (cmd_i.mul_sel)
      3'd0: begin ma = cy_q; mb = cp_q; end
      3'd1: begin ma = sy_q; mb = cp_q; end
      3'd2: begin ma = cy_q; mb = sp_q; end
      default: begin ma = sy_q; mb = sp_q; end
    endcase
    prod   = ma * mb;
    prod_r = VW'((prod + (2*VW)'(1 << (VEC_FRAC_BITS - 1))) >>> VEC_FRAC_BITS);
  end

  logic signed [VW-1:0] mvec [3];
  logic [2:0]           mmask;
  always_comb begin
    mvec[0] = '0; mvec[1] = '0; mvec[2] = '0; mmask = 3'b000;
    case (func_i)
      ecbu_pkg::FuncForward: begin
        mvec[0] = fwd_q[0]; mvec[1] = fwd_q[1]; mvec[2] = fwd_q[2]; mmask = 3'b111;
      end
      ecbu_pkg::FuncBack: begin
        mvec[0] = -fwd_q[0]; mvec[1] = -fwd_q[1]; mvec[2] = -fwd_q[2]; mmask = 3'b111;
      end
      ecbu_pkg::FuncLeft: begin
        mvec[0] = -rgt_q[0]; mvec[2] = -rgt_q[1]; mmask = 3'b101;
      end
      ecbu_pkg::FuncRight: begin
        mvec[0] = rgt_q[0]; mvec[2] = rgt_q[1]; mmask = 3'b101;
      end
      default: mmask = 3'b000;
    endcase
  end

  logic signed [32:0] psum_v [3];
  for (genvar k = 0; k < 3; k++) begin : g_sum
    assign psum_v[k] = 33'(pos_q[k]) + 33'(mvec[k]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_q    <= 18'(90 * (1 << ANGLE_FRAC_BITS));
      pitch_q  <= '0;
      pos_q[0] <= '0;
      pos_q[1] <= '0;
      pos_q[2] <= 32'(-6 * (1 << VEC_FRAC_BITS));
      cstep_q  <= '0;
    end else begin
      if (cmd_i.load_item && func_i == ecbu_pkg::FuncRotate) begin
        yaw_q   <= (ysum > YLim) ? YLim : ((ysum < -YLim) ? -YLim : ysum);
        pitch_q <= (psum > PLim) ? PLim : ((psum < -PLim) ? -PLim : psum);
      end
      if (cmd_i.do_move) begin
        for (int k = 0; k < 3; k++) begin
          if (mmask[k]) begin
            if (psum_v[k] > 33'sh0_7FFF_FFFF) pos_q[k] <= 32'sh7FFF_FFFF;
            else if (psum_v[k] < -33'sh0_8000_0000) pos_q[k] <= 32'sh8000_0000;
            else pos_q[k] <= psum_v[k][31:0];
          end
        end
      end
      if (cmd_i.cordic_start_yaw || cmd_i.cordic_start_pitch) begin
        cstep_q <= '0;
      end else if (cmd_i.cordic_step) begin
        cstep_q <= cstep_q + 5'd1;
      end
    end
  end

  // cordic and sine/cosine registers
  logic mul_phase_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.cordic_start_yaw || cmd_i.cordic_start_pitch) begin
      cx_q   <= ecbu_pkg::CordicX0;
      cyv_q  <= '0;
      ca_q   <= cmd_i.cordic_start_yaw ? red_y[AW-1:0] : red_p[AW-1:0];
      cneg_q <= cmd_i.cordic_start_yaw ? red_y[AW] : red_p[AW];
      mul_phase_q <= cmd_i.cordic_start_pitch;
    end else if (cmd_i.cordic_step) begin
      if (!ca_q[AW-1]) begin
        cx_q  <= cx_q - (cyv_q >>> cstep_q);
        cyv_q <= cyv_q + (cx_q >>> cstep_q);
        ca_q  <= ca_q - ecbu_pkg::atan_deg(cstep_q);
      end else begin
        cx_q  <= cx_q + (cyv_q >>> cstep_q);
        cyv_q <= cyv_q - (cx_q >>> cstep_q);
        ca_q  <= ca_q + ecbu_pkg::atan_deg(cstep_q);
      end
    end else if (cmd_i.cordic_finish) begin
      if (!mul_phase_q) begin
        cy_q <= fin(fx);
        sy_q <= fin(fy);
      end else begin
        cp_q <= fin(fx);
        sp_q <= fin(fy);
      end
    end
  end

  // basis vectors written by the controller's product sequence
  logic mrun_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mrun_q <= 1'b0;
    end else begin
      mrun_q <= cmd_i.cordic_finish && mul_phase_q;
    end
  end

  logic mul_active_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_active_q <= 1'b0;
    end else if (mrun_q) begin
      mul_active_q <= 1'b1;
    end else if (mul_active_q && cmd_i.mul_sel == 3'd3) begin
      mul_active_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q[0] <= '0;
      fwd_q[1] <= '0;
      fwd_q[2] <= OneV;
      rgt_q[0] <= -OneV;
      rgt_q[1] <= '0;
      up_q[0]  <= '0;
      up_q[1]  <= OneV;
      up_q[2]  <= '0;
    end else if (mrun_q || mul_active_q) begin
      case (cmd_i.mul_sel)
        3'd0: fwd_q[0] <= prod_r;
        3'd1: fwd_q[2] <= prod_r;
        3'd2: up_q[0]  <= -prod_r;
        default: up_q[2] <= -prod_r;
      endcase
      fwd_q[1] <= sp_q;
      up_q[1]  <= cp_q;
      rgt_q[0] <= -sy_q;
      rgt_q[1] <= cy_q;
    end
  end

  assign pos_x_o   = pos_q[0];
  assign pos_y_o   = pos_q[1];
  assign pos_z_o   = pos_q[2];
  assign fwd_x_o   = 16'(fwd_q[0]);
  assign fwd_y_o   = 16'(fwd_q[1]);
  assign fwd_z_o   = 16'(fwd_q[2]);
  assign right_x_o = 16'(rgt_q[0]);
  assign right_z_o = 16'(rgt_q[1]);
  assign up_x_o    = 16'(up_q[0]);
  assign up_y_o    = 16'(up_q[1]);
  assign up_z_o    = 16'(up_q[2]);
  assign heading_o = 16'(yaw_q);

endmodule

// ===== design/euler_camera_basis_update.sv =====
// top level of the euler camera basis update block
// Usage: one input channel (func, yaw_delta, pitch_delta) and one result
// channel (position, forward, right, up, heading), both valid/ready.
// Each transfer in gives exactly one transfer out holding the state after
// the update. Move items (forward, back, left, right) and unknown codes
// show the result valid the cycle after the input transfer. A rotate
// item runs the shared cordic unit twice, once for yaw and once for
// pitch, each with a set-up step, CORDIC_STEPS iterations (at most 24)
// and a rounding step, then forms four products through one multiplier.
// One item is in flight at a time; the input is ready again the cycle
// after the result transfer. The result stays held while the receiver
// stalls. Reset sets yaw to ninety degrees, pitch zero, position
// (0, 0, -6.0) and the matching basis.
module euler_camera_basis_update #(
  parameter int VEC_FRAC_BITS   = ecbu_pkg::VecFracBits,
  parameter int ANGLE_FRAC_BITS = ecbu_pkg::AngleFracBits,
  parameter int CORDIC_STEPS    = ecbu_pkg::CordicSteps
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         func_i,
  input  logic signed [15:0] yaw_delta_i,
  input  logic signed [15:0] pitch_delta_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic signed [15:0] fwd_x_o,
  output logic signed [15:0] fwd_y_o,
  output logic signed [15:0] fwd_z_o,
  output logic signed [15:0] right_x_o,
  output logic signed [15:0] right_z_o,
  output logic signed [15:0] up_x_o,
  output logic signed [15:0] up_y_o,
  output logic signed [15:0] up_z_o,
  output logic signed [15:0] heading_o
);

  ecbu_pkg::cmd_t cmd;
  ecbu_pkg::sts_t sts;

  ecbu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ecbu_datapath #(
    .VEC_FRAC_BITS   (VEC_FRAC_BITS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .CORDIC_STEPS    (CORDIC_STEPS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .func_i        (func_i),
    .yaw_delta_i   (yaw_delta_i),
    .pitch_delta_i (pitch_delta_i),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .pos_z_o       (pos_z_o),
    .fwd_x_o       (fwd_x_o),
    .fwd_y_o       (fwd_y_o),
    .fwd_z_o       (fwd_z_o),
    .right_x_o     (right_x_o),
    .right_z_o     (right_z_o),
    .up_x_o        (up_x_o),
    .up_y_o        (up_y_o),
    .up_z_o        (up_z_o),
    .heading_o     (heading_o)
  );

endmodule

// ===== design/ecbu_checker.sv =====
// port-level checker for the euler camera basis update block, with its bind
module ecbu_assertions (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [15:0] heading_i,
  input logic signed [15:0] right_z_i
);

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i)) else $error("ready while result pending");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(heading_i))
    else $error("result dropped under stall");

  a_ready_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i |=> in_ready_i) else $error("no ready after transfer");

  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    heading_i <= 16'sd23040 && heading_i >= -16'sd23040) else $error("heading range");

  a_basis_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i && !in_valid_i |=> $stable(right_z_i)) else $error("basis moved idle");

endmodule

bind euler_camera_basis_update ecbu_assertions u_ecbu_assertions (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .heading_i   (heading_o),
  .right_z_i   (right_z_o)
);
